// ===== rtl/iqse_pkg.sv =====
// shared constants and types of the integer quicksort engine
// no dependencies; used by every module of the block but iqse_ram
`timescale 1ns / 1ps
`default_nettype none

package iqse_pkg;

  localparam int DATA_W        = 32;
  localparam int MAX_ITEMS_DEF = 64;

  // result of the shared signed compare
  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_t;

endpackage

`default_nettype wire

// ===== rtl/iqse_ram.sv =====
// generic single write port, single read port ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module iqse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/iqse_cmp.sv =====
// shared signed compare unit: one 33-bit subtract gives less-than and equal
// depends on iqse_pkg
`timescale 1ns / 1ps
`default_nettype none

module iqse_cmp (
  input  wire logic [iqse_pkg::DATA_W-1:0] a,
  input  wire logic [iqse_pkg::DATA_W-1:0] b,
  output iqse_pkg::cmp_t                   res
);

  logic [iqse_pkg::DATA_W:0] diff;

  assign diff   = {a[iqse_pkg::DATA_W-1], a} - {b[iqse_pkg::DATA_W-1], b};
  assign res.lt = diff[iqse_pkg::DATA_W];
  assign res.eq = (diff == '0);

endmodule

`default_nettype wire

// ===== rtl/iqse_seq.sv =====
// sequencer of the quicksort engine: load, partition loop, range stack, emit
// depends on iqse_pkg; drives the element and range rams and the shared compare
`timescale 1ns / 1ps
`default_nettype none

module iqse_seq #(
  parameter int MAX_ITEMS = iqse_pkg::MAX_ITEMS_DEF
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  // input request
  input  wire logic                                    in_valid,
  output logic                                         in_stall,
  input  wire logic [iqse_pkg::DATA_W-1:0]             value,
  input  wire logic                                    last,
  // result request
  output logic                                         out_valid,
  input  wire logic                                    out_stall,
  output logic [iqse_pkg::DATA_W-1:0]                  sorted_value,
  output logic                                         final_res,
  output logic                                         overflow,
  // element ram
  output logic                                         st_we,
  output logic [$clog2(MAX_ITEMS)-1:0]                 st_waddr,
  output logic [iqse_pkg::DATA_W-1:0]                  st_wdata,
  output logic [$clog2(MAX_ITEMS)-1:0]                 st_raddr,
  input  wire logic [iqse_pkg::DATA_W-1:0]             st_rdata,
  // range ram
  output logic                                         sk_we,
  output logic [$clog2(MAX_ITEMS)-1:0]                 sk_waddr,
  output logic [2*$clog2(MAX_ITEMS)-1:0]               sk_wdata,
  output logic [$clog2(MAX_ITEMS)-1:0]                 sk_raddr,
  input  wire logic [2*$clog2(MAX_ITEMS)-1:0]          sk_rdata,
  // shared compare
  output logic [iqse_pkg::DATA_W-1:0]                  pivot,
  input  wire iqse_pkg::cmp_t                          cmp
);

  localparam int IW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);

  typedef enum logic [12:0] {
    S_LOAD  = 13'b0000000000001,
    S_POP   = 13'b0000000000010,
    S_POPW  = 13'b0000000000100,
    S_PIV   = 13'b0000000001000,
    S_JRD   = 13'b0000000010000,
    S_JCMP  = 13'b0000000100000,
    S_IRD   = 13'b0000001000000,
    S_ICMP  = 13'b0000010000000,
    S_PLACE = 13'b0000100000000,
    S_PUSH2 = 13'b0001000000000,
    S_ERD   = 13'b0010000000000,
    S_ECAP  = 13'b0100000000000,
    S_EWAIT = 13'b1000000000000
  } state_t;

  state_t        state;
  logic [CW-1:0] count;
  logic          ovf;
  logic [IW:0]   sp;
  logic [IW-1:0] lo;
  logic [IW-1:0] hi;
  logic [IW-1:0] i;
  logic [IW-1:0] j;
  logic [IW-1:0] k;

  logic          accept;
  logic          room;
  logic [CW-1:0] count_next;
  logic          i_lt_j;
  logic          sp_room;
  logic [IW-1:0] pop_lo;
  logic [IW-1:0] pop_hi;
  logic          push_left;
  logic          push_right;
  logic          emit_last;

  assign in_stall   = (state != S_LOAD);
  assign accept     = in_valid && !in_stall;
  assign room       = (count < CW'(MAX_ITEMS));
  assign count_next = room ? count + CW'(1) : count;
  assign i_lt_j     = (i < j);
  assign sp_room    = (sp < (IW + 1)'(MAX_ITEMS));
  assign pop_lo     = sk_rdata[2*IW-1:IW];
  assign pop_hi     = sk_rdata[IW-1:0];
  assign push_left  = ({1'b0, i} > ({1'b0, lo} + (IW + 1)'(1))) && sp_room;
  assign push_right = ({1'b0, hi} > ({1'b0, i} + (IW + 1)'(1))) && sp_room;
  assign emit_last  = ((CW'(k) + CW'(1)) == count);

  // ram strobes
  always_comb begin
    st_we    = 1'b0;
    st_waddr = i;
    st_wdata = st_rdata;
    st_raddr = j;
    sk_we    = 1'b0;
    sk_waddr = sp[IW-1:0];
    sk_wdata = {lo, i - IW'(1)};
    sk_raddr = sp[IW-1:0] - IW'(1);
    unique case (state)
      S_LOAD: begin
        st_waddr = count[IW-1:0];
        st_wdata = value;
        st_we    = accept && room;
        sk_waddr = '0;
        sk_wdata = {IW'(0), IW'(count_next - CW'(1))};
        sk_we    = accept && last && (count_next >= CW'(2));
      end
      S_POPW: begin
        st_raddr = pop_lo;
      end
      S_JCMP: begin
        st_waddr = i;
        st_we    = cmp.lt;
      end
      S_IRD: begin
        st_raddr = i;
      end
      S_ICMP: begin
        st_waddr = j;
        st_we    = !(cmp.lt || cmp.eq);
      end
      S_PLACE: begin
        st_waddr = i;
        st_wdata = pivot;
        st_we    = 1'b1;
        sk_wdata = {lo, i - IW'(1)};
        sk_we    = push_left;
      end
      S_PUSH2: begin
        sk_wdata = {i + IW'(1), hi};
        sk_we    = push_right;
      end
      S_ERD: begin
        st_raddr = k;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      count     <= '0;
      ovf       <= 1'b0;
      sp        <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_LOAD: begin
          if (accept) begin
            count <= count_next;
            if (!room) begin
              ovf <= 1'b1;
            end
            if (last) begin
              k <= '0;
              if (count_next >= CW'(2)) begin
                sp    <= (IW + 1)'(1);
                state <= S_POP;
              end else begin
                state <= S_ERD;
              end
            end
          end
        end
        S_POP: begin
          if (sp == '0) begin
            k     <= '0;
            state <= S_ERD;
          end else begin
            sp    <= sp - (IW + 1)'(1);
            state <= S_POPW;
          end
        end
        S_POPW: begin
          lo <= pop_lo;
          hi <= pop_hi;
          i  <= pop_lo;
          j  <= pop_hi;
          state <= (pop_lo >= pop_hi) ? S_POP : S_PIV;
        end
        S_PIV: begin
          pivot <= st_rdata;
          state <= S_JRD;
        end
        S_JRD: begin
          state <= i_lt_j ? S_JCMP : S_PLACE;
        end
        S_JCMP: begin
          if (cmp.lt) begin
            state <= S_IRD;
          end else begin
            j     <= j - IW'(1);
            state <= S_JRD;
          end
        end
        S_IRD: begin
          state <= i_lt_j ? S_ICMP : S_PLACE;
        end
        S_ICMP: begin
          if (cmp.lt || cmp.eq) begin
            i     <= i + IW'(1);
            state <= S_IRD;
          end else begin
            state <= S_JRD;
          end
        end
        S_PLACE: begin
          if (push_left) begin
            sp <= sp + (IW + 1)'(1);
          end
          state <= S_PUSH2;
        end
        S_PUSH2: begin
          if (push_right) begin
            sp <= sp + (IW + 1)'(1);
          end
          state <= S_POP;
        end
        S_ERD: begin
          state <= S_ECAP;
        end
        S_ECAP: begin
          sorted_value <= st_rdata;
          final_res    <= emit_last;
          overflow     <= ovf;
          out_valid    <= 1'b1;
          state        <= S_EWAIT;
        end
        S_EWAIT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            if (final_res) begin
              count <= '0;
              ovf   <= 1'b0;
              state <= S_LOAD;
            end else begin
              k     <= k + IW'(1);
              state <= S_ERD;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/integer_quicksort_engine_unit.sv =====
// Sorts a set of signed 32-bit values, given one per input request with the
// final one marked by last, and returns them in ascending order, duplicates
// kept, final_res on the last result and overflow on every result of a set
// that lost requests beyond MAX_ITEMS. The input is never stalled while a set
// is loading. On the last request the block stalls its input and sorts in
// place: each range is popped from the stack and its first element taken as
// pivot, and every element visited by a partition scan is read from the
// single-read-port element ram and then checked by the shared signed
// comparator, so an already sorted set is the worst case. Each result is then
// read, captured and held on the output until it is taken. No pass over the
// rams is needed after reset.
// depends on iqse_pkg, iqse_ram, iqse_cmp and iqse_seq
`timescale 1ns / 1ps
`default_nettype none

module integer_quicksort_engine_unit #(
  parameter int MAX_ITEMS = iqse_pkg::MAX_ITEMS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [iqse_pkg::DATA_W-1:0] value,
  input  wire logic                        last,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [iqse_pkg::DATA_W-1:0]      sorted_value,
  output logic                             final_res,
  output logic                             overflow
);

  localparam int IW = $clog2(MAX_ITEMS);

  logic                        st_we;
  logic [IW-1:0]               st_waddr;
  logic [iqse_pkg::DATA_W-1:0] st_wdata;
  logic [IW-1:0]               st_raddr;
  logic [iqse_pkg::DATA_W-1:0] st_rdata;
  logic                        sk_we;
  logic [IW-1:0]               sk_waddr;
  logic [2*IW-1:0]             sk_wdata;
  logic [IW-1:0]               sk_raddr;
  logic [2*IW-1:0]             sk_rdata;
  logic [iqse_pkg::DATA_W-1:0] pivot;
  iqse_pkg::cmp_t              cmp;

  // element store
  iqse_ram #(
    .WIDTH (iqse_pkg::DATA_W),
    .DEPTH (MAX_ITEMS)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  // pending range stack, low index above high index
  iqse_ram #(
    .WIDTH (2 * IW),
    .DEPTH (MAX_ITEMS)
  ) u_stack (
    .clk   (clk),
    .we    (sk_we),
    .waddr (sk_waddr),
    .wdata (sk_wdata),
    .raddr (sk_raddr),
    .rdata (sk_rdata)
  );

  iqse_cmp u_cmp (
    .a   (st_rdata),
    .b   (pivot),
    .res (cmp)
  );

  iqse_seq #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .value        (value),
    .last         (last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sorted_value (sorted_value),
    .final_res    (final_res),
    .overflow     (overflow),
    .st_we        (st_we),
    .st_waddr     (st_waddr),
    .st_wdata     (st_wdata),
    .st_raddr     (st_raddr),
    .st_rdata     (st_rdata),
    .sk_we        (sk_we),
    .sk_waddr     (sk_waddr),
    .sk_wdata     (sk_wdata),
    .sk_raddr     (sk_raddr),
    .sk_rdata     (sk_rdata),
    .pivot        (pivot),
    .cmp          (cmp)
  );

endmodule

`default_nettype wire

// ===== tb/iqse_sort_checker.sv =====
// checker for the integer quicksort engine: watches both request channels,
// predicts the sorted results of each set and compares them field by field
// depends on iqse_pkg
`timescale 1ns / 1ps

module iqse_sort_checker #(
  parameter int MAX_ITEMS = iqse_pkg::MAX_ITEMS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  input  wire logic                        in_stall,
  input  wire logic [iqse_pkg::DATA_W-1:0] value,
  input  wire logic                        last,
  input  wire logic                        out_valid,
  input  wire logic                        out_stall,
  input  wire logic [iqse_pkg::DATA_W-1:0] sorted_value,
  input  wire logic                        final_res,
  input  wire logic                        overflow,
  output int                               mismatches,
  output int                               results_due
);

  typedef struct packed {
    logic [iqse_pkg::DATA_W-1:0] value;
    logic                        fin;
    logic                        ovf;
  } sorted_result_t;

  logic [iqse_pkg::DATA_W-1:0] set_store [MAX_ITEMS];
  int                          set_count;
  logic                        set_dropped;
  sorted_result_t              sorted_due [$];
  sorted_result_t              want_res;

  initial begin
    mismatches  = 0;
    results_due = 0;
    set_count   = 0;
    set_dropped = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: %s mismatch, got %0h, expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  // ascending signed order of the stored set, duplicates kept
  function automatic void sort_stored_set();
    logic signed [iqse_pkg::DATA_W-1:0] ordered [MAX_ITEMS];
    logic signed [iqse_pkg::DATA_W-1:0] key;
    int k;
    int j;
    for (k = 0; k < set_count; k++) ordered[k] = set_store[k];
    for (k = 1; k < set_count; k++) begin
      key = ordered[k];
      j = k - 1;
      while (j >= 0 && ordered[j] > key) begin
        ordered[j + 1] = ordered[j];
        j--;
      end
      ordered[j + 1] = key;
    end
    for (k = 0; k < set_count; k++) begin
      sorted_due.push_back('{value: ordered[k], fin: (k == set_count - 1),
                             ovf: set_dropped});
    end
    set_count   = 0;
    set_dropped = 1'b0;
  endfunction

  function automatic void absorb_request(input logic [iqse_pkg::DATA_W-1:0] v,
                                         input logic l);
    if (set_count < MAX_ITEMS) begin
      set_store[set_count] = v;
      set_count++;
    end else begin
      set_dropped = 1'b1;
    end
    if (l) sort_stored_set();
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      sorted_due.delete();
      set_count   = 0;
      set_dropped = 1'b0;
    end else begin
      if (in_valid && !in_stall) absorb_request(value, last);
      if (out_valid && !out_stall) begin
        if (sorted_due.size() == 0) begin
          report_mismatch("unrequested result", sorted_value, '0);
        end else begin
          want_res = sorted_due.pop_front();
          if (sorted_value !== want_res.value)
            report_mismatch("sorted_value", sorted_value, want_res.value);
          if (final_res !== want_res.fin)
            report_mismatch("final_res", 32'(final_res), 32'(want_res.fin));
          if (overflow !== want_res.ovf)
            report_mismatch("overflow", 32'(overflow), 32'(want_res.ovf));
        end
      end
    end
    results_due <= sorted_due.size();
  end

endmodule

// ===== tb/integer_quicksort_engine_unit_test.sv =====
// top of the quicksort engine testbench: clock, reset, request stimulus with
// random idling on both sides, and the verdict
// depends on iqse_pkg, integer_quicksort_engine_unit and iqse_sort_checker
`timescale 1ns / 1ps

module integer_quicksort_engine_unit_test;

  localparam int CAPACITY     = iqse_pkg::MAX_ITEMS_DEF;
  localparam int LIMIT_CYCLES = 500000;
  localparam int DRAIN_CYCLES = 64;
  localparam int RANDOM_ITEMS = 147;
  localparam int CALM_AFTER   = 137;

  typedef enum {FILL_WIDE, FILL_NARROW, FILL_RISING, FILL_FALLING} fill_style_t;

  // bit 32 marks the last request of a set
  localparam logic [32:0] DIRECTED_REQS [23] = '{
    {1'b1, 32'h7fffffff},
    {1'b1, 32'h80000000},
    {1'b0, 32'h7fffffff}, {1'b0, 32'h80000000}, {1'b0, 32'h00000000},
    {1'b0, 32'hffffffff}, {1'b0, 32'h00000001}, {1'b1, 32'h80000000},
    {1'b0, 32'hfffffffe}, {1'b0, 32'hffffffff}, {1'b0, 32'h00000000},
    {1'b0, 32'h00000001}, {1'b1, 32'h00000002},
    {1'b0, 32'h7fffffff}, {1'b0, 32'h7ffffffe}, {1'b0, 32'h00000005},
    {1'b0, 32'h00000000}, {1'b1, 32'h80000001},
    {1'b0, 32'hfffffff9}, {1'b0, 32'hfffffff9}, {1'b1, 32'hfffffff9},
    {1'b0, 32'h00000002}, {1'b1, 32'h00000001}
  };

  logic                        clk = 1'b0;
  logic                        rst;
  logic                        in_valid;
  logic                        in_stall;
  logic [iqse_pkg::DATA_W-1:0] value;
  logic                        last;
  logic                        out_valid;
  logic                        out_stall;
  logic [iqse_pkg::DATA_W-1:0] sorted_value;
  logic                        final_res;
  logic                        overflow;
  bit                          calm;
  int                          stall_left;
  int                          mismatches;
  int                          results_due;

  always #2 clk = ~clk;

  integer_quicksort_engine_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .value(value), .last(last),
    .out_valid(out_valid), .out_stall(out_stall), .sorted_value(sorted_value),
    .final_res(final_res), .overflow(overflow)
  );

  iqse_sort_checker #(.MAX_ITEMS(CAPACITY)) sort_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .value(value), .last(last),
    .out_valid(out_valid), .out_stall(out_stall), .sorted_value(sorted_value),
    .final_res(final_res), .overflow(overflow),
    .mismatches(mismatches), .results_due(results_due)
  );

  // result side back-pressure in bursts
  always @(negedge clk) begin
    if (rst || calm) begin
      out_stall  <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left--;
    end else if ($urandom_range(0, 4) == 0) begin
      out_stall  <= 1'b1;
      stall_left = $urandom_range(1, 6) - 1;
    end else begin
      out_stall  <= 1'b0;
    end
  end

  task automatic send_request(input logic [iqse_pkg::DATA_W-1:0] v, input logic l);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid <= 1'b1;
    value    <= v;
    last     <= l;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic send_random_set(input int size, input fill_style_t style);
    logic [iqse_pkg::DATA_W-1:0] base;
    logic [iqse_pkg::DATA_W-1:0] step;
    logic [iqse_pkg::DATA_W-1:0] v;
    int k;
    base = $urandom;
    step = $urandom_range(0, 1000);
    for (k = 0; k < size; k++) begin
      case (style)
        FILL_WIDE:    v = $urandom;
        FILL_NARROW:  v = 32'($urandom_range(0, 8)) - 32'd4;
        FILL_RISING:  v = base + 32'(k) * step;
        default:      v = base - 32'(k) * step;
      endcase
      send_request(v, k == size - 1);
    end
  endtask

  initial begin
    int sent;
    int size;
    int k;
    rst        = 1'b1;
    in_valid   = 1'b0;
    value      = '0;
    last       = 1'b0;
    out_stall  = 1'b0;
    calm       = 1'b0;
    stall_left = 0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    for (k = 0; k < 23; k++) send_request(DIRECTED_REQS[k][31:0], DIRECTED_REQS[k][32]);

    // a full set, then one that overruns capacity with its last two requests dropped
    send_random_set(CAPACITY, FILL_WIDE);
    send_random_set(CAPACITY + 2, FILL_NARROW);
    sent = 2 * CAPACITY + 2;
    while (sent < RANDOM_ITEMS) begin
      if (sent >= CALM_AFTER) calm = 1'b1;
      size = $urandom_range(1, 10);
      send_random_set(size, fill_style_t'($urandom_range(0, 3)));
      sent += size;
    end
    in_valid <= 1'b0;

    while (results_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (mismatches == 0) begin
      $display("integer_quicksort_engine_unit verification clean");
    end else begin
      $display("integer_quicksort_engine_unit verification failed");
    end
    $finish;
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("integer_quicksort_engine_unit verification failed");
    $finish;
  end

endmodule
